[hw/rtl/labmp_pkg.sv]
// Package for the lidar angular binning block: shared widths, codes and types.
// Used by the top level, labmp_front and labmp_back; it depends on nothing.
`default_nettype none

package labmp_pkg;

    localparam int ANGLE_W    = 16;
    localparam int RANGE_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int FIRST_W    = 10;
    localparam int END_W      = 11;

    localparam logic [RANGE_W-1:0] NO_READING = 16'hFFFF;

    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_START  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_STEP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_FIRST = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_END   = 3'd4;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    typedef enum logic [1:0] {
        CMD_NEW,
        CMD_MIN,
        CMD_QUERY
    } t_cmd_kind;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_RMW_WR,
        B_SCAN,
        B_DONE
    } t_back_state;

    typedef struct packed {
        logic [ANGLE_W-1:0] angle_start;
        logic [ANGLE_W-1:0] angle_step;
        logic [RANGE_W-1:0] alert_threshold_mm;
        logic [FIRST_W-1:0] sector_first_bin;
        logic [END_W-1:0]   sector_end_bin;
    } t_cfg;

endpackage

`default_nettype wire

[hw/rtl/lidar_angle_bin_min_proximity.sv]
// Lidar angular binning with nearest-range keep and sector proximity query.
// Top level; depends on labmp_pkg, labmp_front, labmp_queue and labmp_back.
//
// Items enter through a queue-like port: a transfer happens when i_push is
// high and o_full is low. Opcode 0 is a range sample, opcode 1 a query.
// Results leave through a second queue-like port: o_alert is valid while
// o_empty is low and a transfer happens when i_pop is high as well.
// Configuration registers are written through i_cfg_valid/o_cfg_ready with
// i_cfg_index and i_cfg_data; o_cfg_ready is always high, and writes are
// expected only while the block is idle.
// The front end takes one item per cycle while its two-entry command queue
// has room. The back end writes a sample that opens a bin directly, reads
// then writes the bin for a sample that keeps the smaller range (RAM read
// then write), and reads the sector bin by bin through the single RAM read
// port for a query. A query on an empty sector skips the scan and goes
// straight to its result.
// After reset the back end writes every bin to "no reading", one per cycle;
// o_full stays high meanwhile. When the receiver does not pop, one finished
// result waits in the output register; the front end keeps filling the
// command queue, and o_full rises once it and the front register are full.
`default_nettype none

module lidar_angle_bin_min_proximity #(
    parameter int NUM_BINS = 360
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_push,
    output logic                                  o_full,
    input  wire logic                             i_opcode,
    input  wire logic [labmp_pkg::RANGE_W-1:0]    i_range_mm,
    input  wire logic                             i_last_in_scan,
    output logic                                  o_empty,
    input  wire logic                             i_pop,
    output logic                                  o_alert,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [labmp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [labmp_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int BIN_W = $clog2(NUM_BINS);
    localparam int CMD_W = $bits(labmp_pkg::t_cmd_kind) + BIN_W + labmp_pkg::RANGE_W;

    labmp_pkg::t_cfg  r_cfg;
    logic             clearing;
    logic             q_push, q_full, q_pop, q_empty;
    logic [CMD_W-1:0] q_wr_data, q_rd_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.angle_start        <= 16'd0;
            r_cfg.angle_step         <= 16'd182;
            r_cfg.alert_threshold_mm <= 16'd500;
            r_cfg.sector_first_bin   <= 10'd145;
            r_cfg.sector_end_bin     <= 11'd215;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                labmp_pkg::CFG_ANGLE_START:  r_cfg.angle_start <= i_cfg_data;
                labmp_pkg::CFG_ANGLE_STEP:   r_cfg.angle_step <= i_cfg_data;
                labmp_pkg::CFG_THRESHOLD:    r_cfg.alert_threshold_mm <= i_cfg_data;
                labmp_pkg::CFG_SECTOR_FIRST: begin
                    r_cfg.sector_first_bin <= i_cfg_data[labmp_pkg::FIRST_W-1:0];
                end
                labmp_pkg::CFG_SECTOR_END: begin
                    r_cfg.sector_end_bin <= i_cfg_data[labmp_pkg::END_W-1:0];
                end
                default: r_cfg <= r_cfg;
            endcase
        end
    end

    labmp_front #(
        .NUM_BINS (NUM_BINS),
        .BIN_W    (BIN_W),
        .CMD_W    (CMD_W)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_hold         (clearing),
        .i_push         (i_push),
        .o_full         (o_full),
        .i_opcode       (i_opcode),
        .i_range_mm     (i_range_mm),
        .i_last_in_scan (i_last_in_scan),
        .o_q_push       (q_push),
        .o_q_data       (q_wr_data),
        .i_q_full       (q_full)
    );

    labmp_queue #(
        .WIDTH (CMD_W),
        .DEPTH (2)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wr_data),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rd_data),
        .o_empty (q_empty)
    );

    labmp_back #(
        .NUM_BINS (NUM_BINS),
        .BIN_W    (BIN_W),
        .CMD_W    (CMD_W)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .o_clearing (clearing),
        .i_q_data   (q_rd_data),
        .i_q_empty  (q_empty),
        .o_q_pop    (q_pop),
        .o_empty    (o_empty),
        .i_pop      (i_pop),
        .o_alert    (o_alert)
    );

endmodule

`default_nettype wire

[hw/rtl/labmp_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none

module labmp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 360
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

[hw/rtl/labmp_queue.sv]
// Small register queue that parts the front end from the back end.
// Depends on nothing.
`default_nettype none

module labmp_queue #(
    parameter int WIDTH = 28,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             wr, rd;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(r_wr_ptr + 1'b1);
        end
        if (rd) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(r_rd_ptr + 1'b1);
        end
        if (wr && !rd) begin
            n_count = CNT_W'(r_count + 1'b1);
        end else if (rd && !wr) begin
            n_count = CNT_W'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/labmp_front.sv]
// Front end: accepts items, tracks the scan angle, maps samples to bins and
// classifies each item into a back-end command. Depends on labmp_pkg.
`default_nettype none

module labmp_front #(
    parameter int NUM_BINS = 360,
    parameter int BIN_W    = 9,
    parameter int CMD_W    = 27
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire labmp_pkg::t_cfg               i_cfg,
    input  wire logic                          i_hold,
    input  wire logic                          i_push,
    output logic                               o_full,
    input  wire logic                          i_opcode,
    input  wire logic [labmp_pkg::RANGE_W-1:0] i_range_mm,
    input  wire logic                          i_last_in_scan,
    output logic                               o_q_push,
    output logic      [CMD_W-1:0]              o_q_data,
    input  wire logic                          i_q_full
);

    localparam int PROD_W = labmp_pkg::ANGLE_W + BIN_W;

    logic                            r_valid;
    logic                            r_op;
    logic [labmp_pkg::RANGE_W-1:0]   r_range;
    logic                            r_last;
    logic [BIN_W-1:0]                r_bin;
    logic [labmp_pkg::ANGLE_W-1:0]   r_offset;
    logic [BIN_W-1:0]                r_prev_bin;
    logic                            r_prev_valid;

    logic [labmp_pkg::ANGLE_W-1:0]   angle, neg;
    logic [PROD_W-1:0]               prod;
    logic                            accept, move;
    labmp_pkg::t_cmd_kind            kind;

    assign angle  = labmp_pkg::ANGLE_W'(i_cfg.angle_start + r_offset);
    assign neg    = labmp_pkg::ANGLE_W'(~angle + 1'b1);
    assign prod   = PROD_W'(neg) * PROD_W'(NUM_BINS);

    assign move   = r_valid && !i_q_full;
    assign o_full = i_hold || (r_valid && i_q_full);
    assign accept = i_push && !o_full;

    always_comb begin
        if (r_op == labmp_pkg::OP_QUERY) begin
            kind = labmp_pkg::CMD_QUERY;
        end else if (r_prev_valid && (r_bin == r_prev_bin)) begin
            kind = labmp_pkg::CMD_MIN;
        end else begin
            kind = labmp_pkg::CMD_NEW;
        end
    end

    assign o_q_push = move;
    assign o_q_data = {kind, r_bin, r_range};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_offset     <= '0;
            r_prev_bin   <= '0;
            r_prev_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_valid <= 1'b1;
            end else if (move) begin
                r_valid <= 1'b0;
            end
            if (accept && (i_opcode == labmp_pkg::OP_SAMPLE)) begin
                if (i_last_in_scan) begin
                    r_offset <= '0;
                end else begin
                    r_offset <= labmp_pkg::ANGLE_W'(r_offset + i_cfg.angle_step);
                end
            end
            if (move && (r_op == labmp_pkg::OP_SAMPLE)) begin
                r_prev_bin   <= r_bin;
                r_prev_valid <= !r_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op    <= i_opcode;
            r_range <= i_range_mm;
            r_last  <= i_last_in_scan;
            r_bin   <= prod[PROD_W-1:labmp_pkg::ANGLE_W];
        end
    end

endmodule

`default_nettype wire

[hw/rtl/labmp_back.sv]
// Back end: clears the bin store after reset, carries out bin writes and
// min updates, scans the sector for queries and holds the result.
// Depends on labmp_pkg and labmp_ram.
`default_nettype none

module labmp_back #(
    parameter int NUM_BINS = 360,
    parameter int BIN_W    = 9,
    parameter int CMD_W    = 27
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire labmp_pkg::t_cfg  i_cfg,
    output logic                  o_clearing,
    input  wire logic [CMD_W-1:0] i_q_data,
    input  wire logic             i_q_empty,
    output logic                  o_q_pop,
    output logic                  o_empty,
    input  wire logic             i_pop,
    output logic                  o_alert
);

    localparam int IDX_W = $clog2(NUM_BINS + 1);
    localparam int RW    = labmp_pkg::RANGE_W;

    labmp_pkg::t_back_state r_state, n_state;
    logic [IDX_W-1:0]       r_idx, n_idx;
    logic [IDX_W-1:0]       r_end, n_end;
    logic                   r_pend, n_pend;
    logic                   r_alert, n_alert;
    logic [BIN_W-1:0]       r_bin, n_bin;
    logic [RW-1:0]          r_range, n_range;
    logic                   r_out_valid, n_out_valid;
    logic                   r_out_alert, n_out_alert;

    labmp_pkg::t_cmd_kind   cmd_kind;
    logic [BIN_W-1:0]       cmd_bin;
    logic [RW-1:0]          cmd_range;
    logic [labmp_pkg::END_W-1:0] end_clip;
    logic                   sector_empty;
    logic                   out_free;
    logic                   issue;
    logic                   hit;

    logic                   wr_en, rd_en;
    logic [BIN_W-1:0]       wr_addr, rd_addr;
    logic [RW-1:0]          wr_data, rd_data;

    assign cmd_kind  = labmp_pkg::t_cmd_kind'(i_q_data[CMD_W-1:BIN_W+RW]);
    assign cmd_bin   = i_q_data[BIN_W+RW-1:RW];
    assign cmd_range = i_q_data[RW-1:0];

    assign end_clip = (i_cfg.sector_end_bin > labmp_pkg::END_W'(NUM_BINS))
                    ? labmp_pkg::END_W'(NUM_BINS) : i_cfg.sector_end_bin;
    assign sector_empty = (labmp_pkg::END_W'(i_cfg.sector_first_bin) >= end_clip);

    assign out_free = !r_out_valid || i_pop;
    assign issue    = (r_idx < r_end);
    assign hit      = r_pend && (rd_data != labmp_pkg::NO_READING)
                    && (rd_data <= i_cfg.alert_threshold_mm);

    assign o_q_pop    = (r_state == labmp_pkg::B_IDLE) && !i_q_empty;
    assign o_clearing = (r_state == labmp_pkg::B_CLEAR);
    assign o_empty    = !r_out_valid;
    assign o_alert    = r_out_alert;

    always_comb begin
        n_state = r_state;
        case (r_state)
            labmp_pkg::B_CLEAR: begin
                if (r_idx == IDX_W'(NUM_BINS - 1)) begin
                    n_state = labmp_pkg::B_IDLE;
                end
            end
            labmp_pkg::B_IDLE: begin
                if (!i_q_empty) begin
                    case (cmd_kind)
                        labmp_pkg::CMD_MIN:   n_state = labmp_pkg::B_RMW_WR;
                        labmp_pkg::CMD_QUERY: begin
                            n_state = sector_empty ? labmp_pkg::B_DONE : labmp_pkg::B_SCAN;
                        end
                        default:              n_state = labmp_pkg::B_IDLE;
                    endcase
                end
            end
            labmp_pkg::B_RMW_WR: n_state = labmp_pkg::B_IDLE;
            labmp_pkg::B_SCAN: begin
                if (!issue) begin
                    n_state = labmp_pkg::B_DONE;
                end
            end
            labmp_pkg::B_DONE: begin
                if (out_free) begin
                    n_state = labmp_pkg::B_IDLE;
                end
            end
            default: n_state = labmp_pkg::B_IDLE;
        endcase
    end

    always_comb begin
        n_idx       = r_idx;
        n_end       = r_end;
        n_pend      = 1'b0;
        n_alert     = r_alert;
        n_bin       = r_bin;
        n_range     = r_range;
        n_out_valid = r_out_valid && !i_pop;
        n_out_alert = r_out_alert;
        wr_en       = 1'b0;
        wr_addr     = cmd_bin;
        wr_data     = cmd_range;
        rd_en       = 1'b0;
        rd_addr     = cmd_bin;
        case (r_state)
            labmp_pkg::B_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_idx[BIN_W-1:0];
                wr_data = labmp_pkg::NO_READING;
                n_idx   = IDX_W'(r_idx + 1'b1);
            end
            labmp_pkg::B_IDLE: begin
                if (!i_q_empty) begin
                    case (cmd_kind)
                        labmp_pkg::CMD_NEW: wr_en = 1'b1;
                        labmp_pkg::CMD_MIN: begin
                            rd_en   = 1'b1;
                            n_bin   = cmd_bin;
                            n_range = cmd_range;
                        end
                        labmp_pkg::CMD_QUERY: begin
                            n_alert = 1'b0;
                            n_idx   = IDX_W'(i_cfg.sector_first_bin);
                            n_end   = IDX_W'(end_clip);
                        end
                        default: n_alert = r_alert;
                    endcase
                end
            end
            labmp_pkg::B_RMW_WR: begin
                wr_en   = 1'b1;
                wr_addr = r_bin;
                wr_data = (r_range < rd_data) ? r_range : rd_data;
            end
            labmp_pkg::B_SCAN: begin
                rd_en   = issue;
                rd_addr = r_idx[BIN_W-1:0];
                n_pend  = issue;
                n_alert = r_alert || hit;
                if (issue) begin
                    n_idx = IDX_W'(r_idx + 1'b1);
                end
            end
            labmp_pkg::B_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_alert = r_alert;
                end
            end
            default: n_pend = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= labmp_pkg::B_CLEAR;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_end       <= n_end;
        r_alert     <= n_alert;
        r_bin       <= n_bin;
        r_range     <= n_range;
        r_out_alert <= n_out_alert;
    end

    labmp_ram #(
        .WIDTH (RW),
        .DEPTH (NUM_BINS)
    ) u_bins (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    a_no_pop_while_clearing: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == labmp_pkg::B_CLEAR) |-> !o_q_pop
    ) else $error("command taken during clearing pass");

    a_scan_index_bounded: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == labmp_pkg::B_SCAN) |-> (r_idx <= r_end)
    ) else $error("sector scan ran past its end");

    a_min_read_then_write: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_q_pop && (cmd_kind == labmp_pkg::CMD_MIN)) |=> (r_state == labmp_pkg::B_RMW_WR)
    ) else $error("min update did not follow its read");

    a_no_write_in_scan: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == labmp_pkg::B_SCAN) |-> !wr_en
    ) else $error("bin store written during a sector scan");

endmodule

`default_nettype wire

[dv/lidar_angle_bin_min_proximity_tb.sv]
// Self-checking testbench for lidar_angle_bin_min_proximity: a directed table, then random
// scans and queries over several register settings, checked against the table's alerts or
// an in-bench bin predictor. Depends on labmp_pkg and the RTL of the block only.
module lidar_angle_bin_min_proximity_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_BINS      = 360;
    localparam int SETTLE_CYCLES = 16;
    localparam int STALL_LIMIT   = 4000;
    localparam int RANDOM_ITEMS  = 930;
    localparam int PHASES        = 7;
    localparam int PLAN_LEN      = 39;

    localparam logic [labmp_pkg::CFG_IDX_W-1:0] REG_ORDER [5] = '{
        labmp_pkg::CFG_ANGLE_START, labmp_pkg::CFG_ANGLE_STEP, labmp_pkg::CFG_THRESHOLD,
        labmp_pkg::CFG_SECTOR_FIRST, labmp_pkg::CFG_SECTOR_END
    };

    typedef enum logic {
        ROW_ITEM,
        ROW_REG
    } t_row_kind;

    typedef struct {
        t_row_kind                            kind;
        logic                                 op;
        logic [labmp_pkg::RANGE_W-1:0]        rng;
        logic                                 last;
        bit                                   typed;
        logic                                 alert;
        logic [labmp_pkg::CFG_IDX_W-1:0]      idx;
        logic [labmp_pkg::CFG_DATA_W-1:0]     data;
    } t_plan_row;

    logic                                 i_clk;
    logic                                 i_rst_n;
    logic                                 i_push;
    logic                                 o_full;
    logic                                 i_opcode;
    logic [labmp_pkg::RANGE_W-1:0]        i_range_mm;
    logic                                 i_last_in_scan;
    logic                                 o_empty;
    logic                                 i_pop;
    logic                                 o_alert;
    logic                                 i_cfg_valid;
    logic                                 o_cfg_ready;
    logic [labmp_pkg::CFG_IDX_W-1:0]      i_cfg_index;
    logic [labmp_pkg::CFG_DATA_W-1:0]     i_cfg_data;

    logic [labmp_pkg::RANGE_W-1:0] bin_store [NUM_BINS];
    logic [labmp_pkg::ANGLE_W-1:0] step_offset;
    int                            prev_bin;
    bit                            prev_valid;
    labmp_pkg::t_cfg               regs;
    logic                          alerts_due [$];
    int                            mismatches = 0;
    int                            stall_cycles = 0;
    bit                            push_gaps;
    bit                            pop_gaps;
    t_plan_row                     plan [PLAN_LEN];

    lidar_angle_bin_min_proximity #(
        .NUM_BINS(NUM_BINS)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_push(i_push),
        .o_full(o_full),
        .i_opcode(i_opcode),
        .i_range_mm(i_range_mm),
        .i_last_in_scan(i_last_in_scan),
        .o_empty(o_empty),
        .i_pop(i_pop),
        .o_alert(o_alert),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_plan_row sample_row(input logic [labmp_pkg::RANGE_W-1:0] rng,
                                             input logic last);
        t_plan_row row;
        row = '{ROW_ITEM, labmp_pkg::OP_SAMPLE, rng, last, 1'b0, 1'b0,
                labmp_pkg::CFG_ANGLE_START, '0};
        return row;
    endfunction

    function automatic t_plan_row query_row(input logic alert,
                                            input logic [labmp_pkg::RANGE_W-1:0] rng,
                                            input logic last);
        t_plan_row row;
        row = '{ROW_ITEM, labmp_pkg::OP_QUERY, rng, last, 1'b1, alert,
                labmp_pkg::CFG_ANGLE_START, '0};
        return row;
    endfunction

    function automatic t_plan_row reg_row(input logic [labmp_pkg::CFG_IDX_W-1:0] idx,
                                          input logic [labmp_pkg::CFG_DATA_W-1:0] data);
        t_plan_row row;
        row = '{ROW_REG, labmp_pkg::OP_SAMPLE, '0, 1'b0, 1'b0, 1'b0, idx, data};
        return row;
    endfunction

    task automatic flag_mismatch(input string what);
        $display("%0t ns: alert mismatch: %s", $time, what);
        mismatches++;
    endtask

    task automatic bin_item(input logic op, input logic [labmp_pkg::RANGE_W-1:0] rng,
                            input logic last, input bit typed, input logic typed_alert);
        logic [labmp_pkg::ANGLE_W-1:0] neg_angle;
        int                            bin;
        int                            sector_end;
        logic                          hit;
        if (op == labmp_pkg::OP_QUERY) begin
            hit = 1'b0;
            sector_end = (regs.sector_end_bin > NUM_BINS) ? NUM_BINS : int'(regs.sector_end_bin);
            for (int b = int'(regs.sector_first_bin); b < sector_end; b++) begin
                if (bin_store[b] != labmp_pkg::NO_READING
                    && bin_store[b] <= regs.alert_threshold_mm) begin
                    hit = 1'b1;
                end
            end
            alerts_due.push_back(typed ? typed_alert : hit);
        end else begin
            neg_angle = -(regs.angle_start + step_offset);
            bin = int'((32'(neg_angle) * NUM_BINS) >> 16);
            if (!prev_valid || bin != prev_bin) begin
                bin_store[bin] = rng;
            end else if (rng < bin_store[bin]) begin
                bin_store[bin] = rng;
            end
            prev_bin = bin;
            prev_valid = 1'b1;
            if (last) begin
                step_offset = '0;
                prev_valid = 1'b0;
            end else begin
                step_offset = step_offset + regs.angle_step;
            end
        end
    endtask

    task automatic send_item(input logic op, input logic [labmp_pkg::RANGE_W-1:0] rng,
                             input logic last, input bit typed, input logic typed_alert);
        @(negedge i_clk);
        while (push_gaps && $urandom_range(0, 99) < 37) begin
            i_push <= 1'b0;
            @(negedge i_clk);
        end
        i_push <= 1'b1;
        i_opcode <= op;
        i_range_mm <= rng;
        i_last_in_scan <= last;
        do @(posedge i_clk); while (o_full);
        bin_item(op, rng, last, typed, typed_alert);
    endtask

    task automatic quiesce();
        @(negedge i_clk);
        i_push <= 1'b0;
        while (alerts_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [labmp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [labmp_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            labmp_pkg::CFG_ANGLE_START:  regs.angle_start = data;
            labmp_pkg::CFG_ANGLE_STEP:   regs.angle_step = data;
            labmp_pkg::CFG_THRESHOLD:    regs.alert_threshold_mm = data;
            labmp_pkg::CFG_SECTOR_FIRST: regs.sector_first_bin = data[labmp_pkg::FIRST_W-1:0];
            labmp_pkg::CFG_SECTOR_END:   regs.sector_end_bin = data[labmp_pkg::END_W-1:0];
            default: ;
        endcase
    endtask

    always @(negedge i_clk) begin
        i_pop <= pop_gaps ? ($urandom_range(0, 99) >= 37) : 1'b1;
    end

    always @(posedge i_clk) begin : check_alerts
        logic want;
        if (i_rst_n && i_pop && !o_empty) begin
            if (alerts_due.size() == 0) begin
                flag_mismatch($sformatf("alert=%0b transferred with no query pending", o_alert));
            end else begin
                want = alerts_due.pop_front();
                if (o_alert !== want) begin
                    flag_mismatch($sformatf("got %0b, expected %0b", o_alert, want));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_push && !o_full) || (i_pop && !o_empty) || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("[lidar_angle_bin_min_proximity] ERROR");
            $finish;
        end
    end

    initial begin
        logic [labmp_pkg::CFG_DATA_W-1:0] vals [5];
        logic [labmp_pkg::RANGE_W-1:0]    rng;
        logic                             last;
        int                               scan_len;
        int                               phase_items;
        bit                               broken;

        i_rst_n = 1'b0;
        i_push = 1'b0;
        i_opcode = labmp_pkg::OP_SAMPLE;
        i_range_mm = '0;
        i_last_in_scan = 1'b0;
        i_pop = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = labmp_pkg::CFG_ANGLE_START;
        i_cfg_data = '0;
        push_gaps = 1'b1;
        pop_gaps = 1'b1;
        for (int b = 0; b < NUM_BINS; b++) begin
            bin_store[b] = labmp_pkg::NO_READING;
        end
        step_offset = '0;
        prev_bin = 0;
        prev_valid = 1'b0;
        regs = '{16'd0, 16'd182, 16'd500, 10'd145, 11'd215};

        plan = '{
            query_row(1'b0, labmp_pkg::NO_READING, 1'b1),
            sample_row(16'd0, 1'b1),
            query_row(1'b0, 16'd0, 1'b0),
            reg_row(labmp_pkg::CFG_SECTOR_FIRST, 16'd0),
            query_row(1'b1, 16'h1234, 1'b1),
            reg_row(labmp_pkg::CFG_THRESHOLD, 16'd0),
            query_row(1'b1, 16'd0, 1'b0),
            sample_row(labmp_pkg::NO_READING, 1'b1),
            query_row(1'b0, 16'h8000, 1'b0),
            reg_row(labmp_pkg::CFG_THRESHOLD, 16'd65534),
            reg_row(labmp_pkg::CFG_ANGLE_STEP, 16'd0),
            query_row(1'b0, 16'h7FFF, 1'b1),
            sample_row(labmp_pkg::NO_READING, 1'b0),
            sample_row(16'd700, 1'b0),
            sample_row(labmp_pkg::NO_READING, 1'b0),
            sample_row(16'd800, 1'b1),
            query_row(1'b1, 16'd0, 1'b0),
            reg_row(labmp_pkg::CFG_THRESHOLD, 16'd699),
            query_row(1'b0, 16'd0, 1'b0),
            reg_row(labmp_pkg::CFG_THRESHOLD, 16'd700),
            query_row(1'b1, 16'd0, 1'b0),
            reg_row(labmp_pkg::CFG_SECTOR_END, 16'd1024),
            reg_row(labmp_pkg::CFG_SECTOR_FIRST, 16'd1023),
            query_row(1'b0, 16'd0, 1'b0),
            reg_row(labmp_pkg::CFG_SECTOR_FIRST, 16'd0),
            query_row(1'b1, 16'd0, 1'b0),
            reg_row(labmp_pkg::CFG_SECTOR_END, 16'd0),
            query_row(1'b0, 16'd0, 1'b0),
            reg_row(labmp_pkg::CFG_SECTOR_END, 16'd360),
            reg_row(labmp_pkg::CFG_ANGLE_START, 16'd1),
            sample_row(16'd5, 1'b1),
            reg_row(labmp_pkg::CFG_SECTOR_FIRST, 16'd359),
            query_row(1'b1, 16'd0, 1'b0),
            reg_row(labmp_pkg::CFG_ANGLE_START, 16'hFFFF),
            sample_row(16'd65534, 1'b1),
            reg_row(labmp_pkg::CFG_SECTOR_FIRST, 16'd0),
            reg_row(labmp_pkg::CFG_SECTOR_END, 16'd1),
            reg_row(labmp_pkg::CFG_THRESHOLD, 16'd65534),
            query_row(1'b1, 16'd0, 1'b0)
        };

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < PLAN_LEN; r++) begin
            if (plan[r].kind == ROW_REG) begin
                quiesce();
                write_reg(plan[r].idx, plan[r].data);
                @(negedge i_clk);
                i_cfg_valid <= 1'b0;
            end else begin
                send_item(plan[r].op, plan[r].rng, plan[r].last, plan[r].typed, plan[r].alert);
            end
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            quiesce();
            case (phase)
                0: vals = '{16'd0, 16'd182, 16'd500, 16'd145, 16'd215};
                1: vals = '{16'hFFFF, 16'hFFFF, 16'd65534, 16'd0, 16'd1024};
                2: vals = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd360};
                default: begin
                    vals[0] = 16'($urandom);
                    vals[1] = $urandom_range(0, 1) ? 16'($urandom_range(1, 400)) : 16'($urandom);
                    vals[2] = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65534))
                                                          : 16'($urandom_range(0, 3000));
                    vals[3] = 16'($urandom_range(0, NUM_BINS - 1));
                    vals[4] = 16'($urandom_range(0, 1024));
                end
            endcase
            for (int i = 0; i < 5; i++) begin
                write_reg(REG_ORDER[i], vals[i]);
            end
            @(negedge i_clk);
            i_cfg_valid <= 1'b0;
            push_gaps = (phase != 1);
            pop_gaps = (phase != 1);

            phase_items = 0;
            while (phase_items < RANDOM_ITEMS / PHASES) begin
                scan_len = ($urandom_range(0, 7) == 0) ? $urandom_range(200, 400)
                                                      : $urandom_range(1, 60);
                broken = ($urandom_range(0, 9) == 0);
                for (int k = 0; k < scan_len && phase_items < RANDOM_ITEMS / PHASES; k++) begin
                    if ($urandom_range(0, 99) < 15) begin
                        send_item(labmp_pkg::OP_QUERY, 16'($urandom), 1'($urandom), 1'b0, 1'b0);
                        phase_items++;
                    end
                    case ($urandom_range(0, 9))
                        0:       rng = labmp_pkg::NO_READING;
                        1:       rng = '0;
                        2, 3, 4: rng = 16'($urandom_range(0, 3000));
                        default: rng = 16'($urandom);
                    endcase
                    last = broken ? ($urandom_range(0, 19) == 0) : (k == scan_len - 1);
                    send_item(labmp_pkg::OP_SAMPLE, rng, last, 1'b0, 1'b0);
                    phase_items++;
                end
            end
        end

        quiesce();
        if (mismatches == 0) begin
            $display("[lidar_angle_bin_min_proximity] OK");
        end else begin
            $display("[lidar_angle_bin_min_proximity] ERROR");
        end
        $finish;
    end

endmodule
